// ===== sv/i2cm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared request and result types, command codes and status codes.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // Raw command codes as they arrive on the request port.
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NACK    = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    localparam logic [7:0] STRETCH_LIMIT_RESET = 8'd10;

    // One request: one bus sample plus an optional command.
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] tx_data;
        logic       nack_after_read;
        logic       scl_in;
        logic       sda_in;
    } req_item_t;

    // One result: line drives and status after the tick.
    typedef struct packed {
        logic       scl_drive_low;
        logic       sda_drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_data;
        logic [1:0] status;
        logic       bus_active;
    } res_item_t;

    // Command after classification; unused codes fold into KIND_NONE.
    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_START,
        KIND_STOP,
        KIND_WRITE,
        KIND_READ
    } cmd_kind_t;

    // Classified request handed from the front end to the sequencer.
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] tx_data;
        logic       nack_after_read;
        logic       scl_in;
        logic       sda_in;
    } bus_step_t;

endpackage

// ===== sv/i2cm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master small queue
// Register-based FIFO; write and read can share a cycle unless full or empty.
// ----------------------------------------------------------------------------
module i2cm_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] wr_data,
    output logic              full,
    input  logic              rd_en,
    output logic [DATA_W-1:0] rd_data,
    output logic              empty
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW-1:0]     rd_ptr_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              do_wr;
    logic              do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== sv/i2cm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master front end
// Accepts requests, decodes the command code and queues the classified step.
// ----------------------------------------------------------------------------
module i2cm_front #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  i2cm_pkg::req_item_t  request,
    output i2cm_pkg::bus_step_t  step,
    output logic                 step_valid,
    input  logic                 step_take
);
    i2cm_pkg::bus_step_t classified;
    logic                q_empty;

    always_comb
    begin
        unique case (request.cmd)
            i2cm_pkg::CMD_START: classified.kind = i2cm_pkg::KIND_START;
            i2cm_pkg::CMD_STOP:  classified.kind = i2cm_pkg::KIND_STOP;
            i2cm_pkg::CMD_WRITE: classified.kind = i2cm_pkg::KIND_WRITE;
            i2cm_pkg::CMD_READ:  classified.kind = i2cm_pkg::KIND_READ;
            default:             classified.kind = i2cm_pkg::KIND_NONE;
        endcase
        classified.tx_data         = request.tx_data;
        classified.nack_after_read = request.nack_after_read;
        classified.scl_in          = request.scl_in;
        classified.sda_in          = request.sda_in;
    end

    i2cm_queue #(
        .DATA_W ($bits(i2cm_pkg::bus_step_t)),
        .DEPTH  (DEPTH)
    ) u_step_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (classified),
        .full    (full),
        .rd_en   (step_take),
        .rd_data (step),
        .empty   (q_empty)
    );

    assign step_valid = !q_empty;

endmodule

// ===== sv/i2cm_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Advances the START / STOP / byte transfer state machine by one bus sample.
// ----------------------------------------------------------------------------
module i2cm_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    input  i2cm_pkg::bus_step_t  step,
    input  logic                 step_valid,
    output logic                 step_take,
    output i2cm_pkg::res_item_t  result,
    output logic                 result_push,
    input  logic                 result_full
);
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST_BEGIN,
        PH_ST_WAIT,
        PH_ST_SCL,
        PH_SP_SDA,
        PH_SP_REL,
        PH_SP_WAIT,
        PH_WR_BIT,
        PH_REL_SCL,
        PH_WR_WAIT,
        PH_REL_BOTH,
        PH_WR_AWAIT,
        PH_RD_WAIT,
        PH_RD_ABIT,
        PH_RD_AWAIT
    } phase_t;

    phase_t     phase_reg,         phase_next;
    logic       is_write_reg,      is_write_next;
    logic [3:0] bit_count_reg,     bit_count_next;
    logic [7:0] shifter_reg,       shifter_next;
    logic [7:0] stretch_count_reg, stretch_count_next;
    logic       active_reg,        active_next;
    logic [1:0] status_reg,        status_next;
    logic       ack_choice_reg,    ack_choice_next;
    logic       scl_drv_reg,       scl_drv_next;
    logic       sda_drv_reg,       sda_drv_next;
    logic [7:0] rx_hold_reg,       rx_hold_next;
    logic [7:0] stretch_limit_reg;

    logic       done_now;
    logic       wait_low;
    logic       wait_tout;
    logic [3:0] bit_count_inc;

    assign step_take   = step_valid && !result_full;
    assign result_push = step_take;

    // SCL still held low by a slave: either keep waiting or give up.
    assign wait_tout     = !step.scl_in && (stretch_count_reg >= stretch_limit_reg);
    assign wait_low      = !step.scl_in && !wait_tout;
    assign bit_count_inc = bit_count_reg + 4'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        is_write_next      = is_write_reg;
        bit_count_next     = bit_count_reg;
        shifter_next       = shifter_reg;
        stretch_count_next = stretch_count_reg;
        active_next        = active_reg;
        status_next        = status_reg;
        ack_choice_next    = ack_choice_reg;
        scl_drv_next       = scl_drv_reg;
        sda_drv_next       = sda_drv_reg;
        rx_hold_next       = rx_hold_reg;
        done_now           = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (step.kind != i2cm_pkg::KIND_NONE)
                begin
                    is_write_next  = (step.kind == i2cm_pkg::KIND_WRITE);
                    status_next    = i2cm_pkg::ST_OK;
                    bit_count_next = 4'd0;
                end
                case (step.kind)
                    i2cm_pkg::KIND_START: phase_next = PH_ST_BEGIN;
                    i2cm_pkg::KIND_STOP:  phase_next = PH_SP_SDA;
                    i2cm_pkg::KIND_WRITE:
                    begin
                        shifter_next = step.tx_data;
                        phase_next   = PH_WR_BIT;
                    end
                    i2cm_pkg::KIND_READ:
                    begin
                        shifter_next    = 8'd0;
                        ack_choice_next = step.nack_after_read;
                        phase_next      = PH_REL_BOTH;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            PH_ST_BEGIN:
            begin
                if (active_reg)
                begin
                    // Repeated START: release both lines and wait for SCL high.
                    sda_drv_next       = 1'b0;
                    scl_drv_next       = 1'b0;
                    stretch_count_next = 8'd0;
                    phase_next         = PH_ST_WAIT;
                end
                else
                begin
                    sda_drv_next = 1'b1;
                    phase_next   = PH_ST_SCL;
                end
            end
            PH_ST_WAIT:
            begin
                if (wait_low)
                begin
                    stretch_count_next = stretch_count_reg + 8'd1;
                end
                else if (wait_tout)
                begin
                    status_next = i2cm_pkg::ST_TIMEOUT;
                    done_now    = 1'b1;
                end
                else
                begin
                    sda_drv_next = 1'b1;
                    phase_next   = PH_ST_SCL;
                end
            end
            PH_ST_SCL:
            begin
                scl_drv_next = 1'b1;
                active_next  = 1'b1;
                done_now     = 1'b1;
            end
            PH_SP_SDA:
            begin
                sda_drv_next = 1'b1;
                phase_next   = PH_SP_REL;
            end
            PH_SP_REL:
            begin
                scl_drv_next       = 1'b0;
                stretch_count_next = 8'd0;
                phase_next         = PH_SP_WAIT;
            end
            PH_SP_WAIT:
            begin
                if (wait_low)
                begin
                    stretch_count_next = stretch_count_reg + 8'd1;
                end
                else
                begin
                    if (wait_tout)
                    begin
                        status_next = i2cm_pkg::ST_TIMEOUT;
                    end
                    sda_drv_next = 1'b0;
                    active_next  = 1'b0;
                    done_now     = 1'b1;
                end
            end
            PH_WR_BIT:
            begin
                sda_drv_next = !shifter_reg[7];
                phase_next   = PH_REL_SCL;
            end
            PH_REL_SCL:
            begin
                scl_drv_next       = 1'b0;
                stretch_count_next = 8'd0;
                phase_next         = is_write_reg ? PH_WR_WAIT : PH_RD_AWAIT;
            end
            PH_WR_WAIT:
            begin
                if (wait_low)
                begin
                    stretch_count_next = stretch_count_reg + 8'd1;
                end
                else
                begin
                    if (wait_tout)
                    begin
                        status_next = i2cm_pkg::ST_TIMEOUT;
                    end
                    scl_drv_next   = 1'b1;
                    shifter_next   = {shifter_reg[6:0], 1'b0};
                    bit_count_next = bit_count_inc;
                    if (bit_count_inc >= 4'd8)
                    begin
                        // A timeout on any data bit skips the ACK slot.
                        if (status_next == i2cm_pkg::ST_TIMEOUT)
                        begin
                            done_now = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_REL_BOTH;
                        end
                    end
                    else
                    begin
                        phase_next = PH_WR_BIT;
                    end
                end
            end
            PH_REL_BOTH:
            begin
                sda_drv_next       = 1'b0;
                scl_drv_next       = 1'b0;
                stretch_count_next = 8'd0;
                phase_next         = is_write_reg ? PH_WR_AWAIT : PH_RD_WAIT;
            end
            PH_WR_AWAIT:
            begin
                if (wait_low)
                begin
                    stretch_count_next = stretch_count_reg + 8'd1;
                end
                else
                begin
                    if (wait_tout)
                    begin
                        status_next = i2cm_pkg::ST_TIMEOUT;
                    end
                    else if (step.sda_in)
                    begin
                        status_next = i2cm_pkg::ST_NACK;
                    end
                    scl_drv_next = 1'b1;
                    done_now     = 1'b1;
                end
            end
            PH_RD_WAIT:
            begin
                if (wait_low)
                begin
                    stretch_count_next = stretch_count_reg + 8'd1;
                end
                else
                begin
                    if (wait_tout)
                    begin
                        status_next = i2cm_pkg::ST_TIMEOUT;
                    end
                    else
                    begin
                        shifter_next = {shifter_reg[6:0], step.sda_in};
                    end
                    scl_drv_next   = 1'b1;
                    bit_count_next = bit_count_inc;
                    phase_next     = (bit_count_inc >= 4'd8) ? PH_RD_ABIT : PH_REL_BOTH;
                end
            end
            PH_RD_ABIT:
            begin
                sda_drv_next = !ack_choice_reg;
                phase_next   = PH_REL_SCL;
            end
            PH_RD_AWAIT:
            begin
                if (wait_low)
                begin
                    stretch_count_next = stretch_count_reg + 8'd1;
                end
                else
                begin
                    if (wait_tout)
                    begin
                        status_next = i2cm_pkg::ST_TIMEOUT;
                    end
                    scl_drv_next = 1'b1;
                    rx_hold_next = shifter_reg;
                    done_now     = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (done_now)
        begin
            phase_next = PH_IDLE;
        end

        result.scl_drive_low = scl_drv_next;
        result.sda_drive_low = sda_drv_next;
        result.busy_res      = (phase_next != PH_IDLE);
        result.done_res      = done_now;
        result.rx_data       = rx_hold_next;
        result.status        = status_next;
        result.bus_active    = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            is_write_reg      <= 1'b0;
            bit_count_reg     <= 4'd0;
            shifter_reg       <= 8'd0;
            stretch_count_reg <= 8'd0;
            active_reg        <= 1'b0;
            status_reg        <= i2cm_pkg::ST_OK;
            ack_choice_reg    <= 1'b0;
            scl_drv_reg       <= 1'b0;
            sda_drv_reg       <= 1'b0;
            rx_hold_reg       <= 8'd0;
            stretch_limit_reg <= i2cm_pkg::STRETCH_LIMIT_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                stretch_limit_reg <= cfg_wr_data;
            end
            if (step_take)
            begin
                phase_reg         <= phase_next;
                is_write_reg      <= is_write_next;
                bit_count_reg     <= bit_count_next;
                shifter_reg       <= shifter_next;
                stretch_count_reg <= stretch_count_next;
                active_reg        <= active_next;
                status_reg        <= status_next;
                ack_choice_reg    <= ack_choice_next;
                scl_drv_reg       <= scl_drv_next;
                sda_drv_reg       <= sda_drv_next;
                rx_hold_reg       <= rx_hold_next;
            end
        end
    end

endmodule

// ===== sv/i2c_master_byte_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine
// Open-drain I2C master driven one bus sample per request.
// ----------------------------------------------------------------------------
// Each request carries one sample of SCL and SDA and an optional command; each
// request produces exactly one result with the line drives and status after
// that sample. The engine takes one request per clock and sustains one result
// per clock while neither side stalls: the sequencer works out a whole tick
// combinationally as its request is taken, so the rate is set only by the two
// small queues, which hold requests and results in registers and let request
// and result sides stall independently. Commands are taken only while the
// sequencer is idle; others are dropped. The stretch limit register may be
// written only while no request is outstanding.
module i2c_master_byte_engine #(
    parameter int QUEUE_DEPTH  = 2,
    parameter int RESULT_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  i2cm_pkg::req_item_t request,
    output logic                empty,
    input  logic                pop,
    output i2cm_pkg::res_item_t result,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data
);
    i2cm_pkg::bus_step_t step;
    logic                step_valid;
    logic                step_take;
    i2cm_pkg::res_item_t seq_result;
    logic                result_push;
    logic                result_full;

    i2cm_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .request    (request),
        .step       (step),
        .step_valid (step_valid),
        .step_take  (step_take)
    );

    i2cm_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (step),
        .step_valid  (step_valid),
        .step_take   (step_take),
        .result      (seq_result),
        .result_push (result_push),
        .result_full (result_full)
    );

    i2cm_queue #(
        .DATA_W ($bits(i2cm_pkg::res_item_t)),
        .DEPTH  (RESULT_DEPTH)
    ) u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (result_push),
        .wr_data (seq_result),
        .full    (result_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

// ===== sv/i2cm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master port checker
// Port-level checks on request and result ordering and result contents.
// ----------------------------------------------------------------------------
module i2cm_checker #(
    parameter int CAPACITY = 4
) (
    input logic                clk,
    input logic                rst_n,
    input logic                push,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input i2cm_pkg::res_item_t result
);
    localparam int CW = $clog2(CAPACITY + 1) + 1;

    logic [CW-1:0] pending_reg;
    logic [CW-1:0] pending_next;
    logic          req_acc;
    logic          res_acc;

    assign req_acc = push && !full;
    assign res_acc = pop && !empty;

    always_comb
    begin
        pending_next = pending_reg;
        if (req_acc && !res_acc)
        begin
            pending_next = pending_reg + CW'(1);
        end
        else if (res_acc && !req_acc)
        begin
            pending_next = pending_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A result is only ever shown for a request that was taken.
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg == '0) |-> empty)
        else $error("result shown with no request outstanding");

    // The engine holds no more requests than its queues can store.
    a_capacity_full: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg >= CW'(CAPACITY)) |-> full)
        else $error("request side not full at storage capacity");

    // A finished command never reports itself as still busy.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(result.done_res && result.busy_res))
        else $error("result marks done and busy together");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.status == i2cm_pkg::ST_OK ||
                    result.status == i2cm_pkg::ST_NACK ||
                    result.status == i2cm_pkg::ST_TIMEOUT))
        else $error("result status code out of range");

endmodule

bind i2c_master_byte_engine i2cm_checker #(
    .CAPACITY (QUEUE_DEPTH + RESULT_DEPTH)
) u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine testbench
// Sends one bus sample per request and predicts the line drives, flags,
// received byte and status of every result with a cycle-accurate model of the
// bit sequencer. It covers directed commands, clock-stretch timeouts in every
// wait state, random transfers under several stretch limits, and stalls on
// both sides of the block.
// ----------------------------------------------------------------------------
module testbench;

    typedef enum logic [3:0] {
        P_IDLE,
        P_ST_BEGIN,
        P_ST_WAIT,
        P_ST_SCL,
        P_SP_SDA,
        P_SP_REL,
        P_SP_WAIT,
        P_WR_BIT,
        P_REL_SCL,
        P_WR_WAIT,
        P_REL_BOTH,
        P_WR_AWAIT,
        P_RD_WAIT,
        P_RD_ABIT,
        P_RD_AWAIT
    } seq_phase_t;

    typedef enum logic [1:0] {
        LINE_LOW,
        LINE_HIGH,
        LINE_TIMEOUT
    } line_wait_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                push;
    logic                full;
    i2cm_pkg::req_item_t request;
    logic                empty;
    logic                pop;
    i2cm_pkg::res_item_t result;
    logic                cfg_wr_en;
    logic [7:0]          cfg_wr_data;

    // Model of the engine state.
    seq_phase_t eng_phase;
    logic [2:0] eng_cmd;
    logic [3:0] eng_bits;
    logic [7:0] eng_shift;
    logic [7:0] eng_stretch;
    logic       eng_active;
    logic [1:0] eng_status;
    logic       eng_ack_nack;
    logic       eng_scl_low;
    logic       eng_sda_low;
    logic [7:0] eng_rx;
    logic [7:0] eng_limit;

    i2cm_pkg::res_item_t tick_results_due[$];
    i2cm_pkg::req_item_t bus_script[$];

    // Stimulus controls.
    bit         gaps_on = 1'b1;
    int         scl_low_pct = 0;
    int         nack_pct = 20;
    int         busy_noise_pct = 0;
    bit         force_low_en = 1'b0;
    seq_phase_t force_phase = P_IDLE;
    int         force_bit = -1;
    int         pop_hold = 0;
    int         pop_stall = 0;

    int         error_count = 0;
    int         results_checked = 0;
    int         ticks_sent = 0;
    int         cmds_taken[5];
    int         done_by_status[4];

    i2c_master_byte_engine dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .request     (request),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void reset_engine_model();
        eng_phase    = P_IDLE;
        eng_cmd      = i2cm_pkg::CMD_NONE;
        eng_bits     = 4'd0;
        eng_shift    = 8'd0;
        eng_stretch  = 8'd0;
        eng_active   = 1'b0;
        eng_status   = i2cm_pkg::ST_OK;
        eng_ack_nack = 1'b0;
        eng_scl_low  = 1'b0;
        eng_sda_low  = 1'b0;
        eng_rx       = 8'd0;
        eng_limit    = i2cm_pkg::STRETCH_LIMIT_RESET;
    endfunction

    // One sample of SCL while the engine waits for a released clock to rise.
    function automatic line_wait_t sample_scl(input logic scl);
        if (scl)
            return LINE_HIGH;
        if (eng_stretch >= eng_limit)
            return LINE_TIMEOUT;
        eng_stretch = eng_stretch + 8'd1;
        return LINE_LOW;
    endfunction

    function automatic i2cm_pkg::res_item_t advance_engine(input i2cm_pkg::req_item_t r);
        logic                done;
        line_wait_t          w;
        i2cm_pkg::res_item_t o;
        done = 1'b0;
        case (eng_phase)
            P_IDLE:
            begin
                if (r.cmd >= i2cm_pkg::CMD_START && r.cmd <= i2cm_pkg::CMD_READ)
                begin
                    eng_cmd    = r.cmd;
                    eng_status = i2cm_pkg::ST_OK;
                    eng_bits   = 4'd0;
                    cmds_taken[r.cmd]++;
                    case (r.cmd)
                        i2cm_pkg::CMD_START: eng_phase = P_ST_BEGIN;
                        i2cm_pkg::CMD_STOP:  eng_phase = P_SP_SDA;
                        i2cm_pkg::CMD_WRITE:
                        begin
                            eng_shift = r.tx_data;
                            eng_phase = P_WR_BIT;
                        end
                        default:
                        begin
                            eng_shift    = 8'd0;
                            eng_ack_nack = r.nack_after_read;
                            eng_phase    = P_REL_BOTH;
                        end
                    endcase
                end
            end
            P_ST_BEGIN:
            begin
                if (eng_active)
                begin
                    // Repeated START: release both lines and wait for SCL high.
                    eng_sda_low = 1'b0;
                    eng_scl_low = 1'b0;
                    eng_stretch = 8'd0;
                    eng_phase   = P_ST_WAIT;
                end
                else
                begin
                    eng_sda_low = 1'b1;
                    eng_phase   = P_ST_SCL;
                end
            end
            P_ST_WAIT:
            begin
                w = sample_scl(r.scl_in);
                if (w == LINE_HIGH)
                begin
                    eng_sda_low = 1'b1;
                    eng_phase   = P_ST_SCL;
                end
                else if (w == LINE_TIMEOUT)
                begin
                    eng_status = i2cm_pkg::ST_TIMEOUT;
                    done       = 1'b1;
                end
            end
            P_ST_SCL:
            begin
                eng_scl_low = 1'b1;
                eng_active  = 1'b1;
                done        = 1'b1;
            end
            P_SP_SDA:
            begin
                eng_sda_low = 1'b1;
                eng_phase   = P_SP_REL;
            end
            P_SP_REL:
            begin
                eng_scl_low = 1'b0;
                eng_stretch = 8'd0;
                eng_phase   = P_SP_WAIT;
            end
            P_SP_WAIT:
            begin
                w = sample_scl(r.scl_in);
                if (w != LINE_LOW)
                begin
                    if (w == LINE_TIMEOUT)
                        eng_status = i2cm_pkg::ST_TIMEOUT;
                    eng_sda_low = 1'b0;
                    eng_active  = 1'b0;
                    done        = 1'b1;
                end
            end
            P_WR_BIT:
            begin
                eng_sda_low = ~eng_shift[7];
                eng_phase   = P_REL_SCL;
            end
            P_REL_SCL:
            begin
                eng_scl_low = 1'b0;
                eng_stretch = 8'd0;
                eng_phase   = (eng_cmd == i2cm_pkg::CMD_WRITE) ? P_WR_WAIT : P_RD_AWAIT;
            end
            P_WR_WAIT:
            begin
                w = sample_scl(r.scl_in);
                if (w != LINE_LOW)
                begin
                    if (w == LINE_TIMEOUT)
                        eng_status = i2cm_pkg::ST_TIMEOUT;
                    eng_scl_low = 1'b1;
                    eng_shift   = {eng_shift[6:0], 1'b0};
                    eng_bits    = eng_bits + 4'd1;
                    if (eng_bits >= 4'd8)
                    begin
                        // A timed-out write skips the ACK slot.
                        if (eng_status == i2cm_pkg::ST_TIMEOUT)
                            done = 1'b1;
                        else
                            eng_phase = P_REL_BOTH;
                    end
                    else
                    begin
                        eng_phase = P_WR_BIT;
                    end
                end
            end
            P_REL_BOTH:
            begin
                eng_sda_low = 1'b0;
                eng_scl_low = 1'b0;
                eng_stretch = 8'd0;
                eng_phase   = (eng_cmd == i2cm_pkg::CMD_WRITE) ? P_WR_AWAIT : P_RD_WAIT;
            end
            P_WR_AWAIT:
            begin
                w = sample_scl(r.scl_in);
                if (w != LINE_LOW)
                begin
                    if (w == LINE_TIMEOUT)
                        eng_status = i2cm_pkg::ST_TIMEOUT;
                    else if (r.sda_in)
                        eng_status = i2cm_pkg::ST_NACK;
                    eng_scl_low = 1'b1;
                    done        = 1'b1;
                end
            end
            P_RD_WAIT:
            begin
                w = sample_scl(r.scl_in);
                if (w != LINE_LOW)
                begin
                    if (w == LINE_HIGH)
                        eng_shift = {eng_shift[6:0], r.sda_in};
                    else
                        eng_status = i2cm_pkg::ST_TIMEOUT;
                    eng_scl_low = 1'b1;
                    eng_bits    = eng_bits + 4'd1;
                    eng_phase   = (eng_bits >= 4'd8) ? P_RD_ABIT : P_REL_BOTH;
                end
            end
            P_RD_ABIT:
            begin
                eng_sda_low = ~eng_ack_nack;
                eng_phase   = P_REL_SCL;
            end
            P_RD_AWAIT:
            begin
                w = sample_scl(r.scl_in);
                if (w != LINE_LOW)
                begin
                    if (w == LINE_TIMEOUT)
                        eng_status = i2cm_pkg::ST_TIMEOUT;
                    eng_scl_low = 1'b1;
                    eng_rx      = eng_shift;
                    done        = 1'b1;
                end
            end
            default:
            begin
                eng_phase = P_IDLE;
            end
        endcase

        if (done)
        begin
            eng_phase = P_IDLE;
            done_by_status[eng_status]++;
        end

        o.scl_drive_low = eng_scl_low;
        o.sda_drive_low = eng_sda_low;
        o.busy_res      = (eng_phase != P_IDLE);
        o.done_res      = done;
        o.rx_data       = eng_rx;
        o.status        = eng_status;
        o.bus_active    = eng_active;
        return o;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (!gaps_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Builds one request; the line levels follow the sequencer's current wait.
    function automatic i2cm_pkg::req_item_t bus_tick(input logic [2:0] code,
                                                     input logic [7:0] data,
                                                     input logic nack);
        i2cm_pkg::req_item_t t;
        logic                forced;
        forced = force_low_en && eng_phase == force_phase &&
                 (force_bit < 0 || force_bit == int'(eng_bits));
        t.cmd             = code;
        t.tx_data         = data;
        t.nack_after_read = nack;
        t.scl_in          = forced ? 1'b0 : ($urandom_range(0, 99) >= scl_low_pct);
        t.sda_in          = (eng_phase == P_WR_AWAIT) ? ($urandom_range(0, 99) < nack_pct)
                                                      : 1'($urandom_range(0, 1));
        return t;
    endfunction

    function automatic logic [2:0] busy_cmd();
        if ($urandom_range(0, 99) < busy_noise_pct)
            return 3'($urandom_range(1, 7));
        return i2cm_pkg::CMD_NONE;
    endfunction

    function automatic i2cm_pkg::req_item_t script_op(input logic [2:0] code,
                                                      input logic [7:0] data,
                                                      input logic nack);
        i2cm_pkg::req_item_t t;
        t = '0;
        t.cmd             = code;
        t.tx_data         = data;
        t.nack_after_read = nack;
        return t;
    endfunction

    // Queues one well-formed transfer: START, address, data bytes, an optional repeated START and address, STOP.
    function automatic void plan_transaction();
        logic [7:0] addr;
        int         n_ops;
        addr  = 8'($urandom);
        n_ops = $urandom_range(1, 3);
        bus_script.push_back(script_op(i2cm_pkg::CMD_START, 8'($urandom), 1'b0));
        bus_script.push_back(script_op(i2cm_pkg::CMD_WRITE, addr, 1'b0));
        for (int i = 0; i < n_ops; i++)
        begin
            if (addr[0])
                bus_script.push_back(script_op(i2cm_pkg::CMD_READ, 8'($urandom),
                                               i == n_ops - 1));
            else
                bus_script.push_back(script_op(i2cm_pkg::CMD_WRITE, 8'($urandom), 1'b0));
        end
        if ($urandom_range(0, 4) == 0)
        begin
            bus_script.push_back(script_op(i2cm_pkg::CMD_START, 8'($urandom), 1'b0));
            bus_script.push_back(script_op(i2cm_pkg::CMD_WRITE, 8'($urandom), 1'b0));
        end
        bus_script.push_back(script_op(i2cm_pkg::CMD_STOP, 8'($urandom), 1'b0));
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input i2cm_pkg::req_item_t item);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push    <= 1'b1;
        request <= item;
        @(posedge clk);
        while (full)
            @(posedge clk);
        tick_results_due.push_back(advance_engine(item));
        ticks_sent++;
        @(negedge clk);
    endtask

    // Sends a command and then samples (with optional noise commands) until the sequencer is idle again.
    task automatic issue(input logic [2:0] code, input logic [7:0] data, input logic nack);
        send_request(bus_tick(code, data, nack));
        while (eng_phase != P_IDLE)
            send_request(bus_tick(busy_cmd(), 8'($urandom), 1'($urandom)));
    endtask

    task automatic wait_for_drain();
        push <= 1'b0;
        while (tick_results_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_stretch_limit(input logic [7:0] value);
        wait_for_drain();
        repeat (4) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        eng_limit = value;
    endtask

    task automatic hold_scl_low(input seq_phase_t ph, input int bit_index);
        force_low_en = 1'b1;
        force_phase  = ph;
        force_bit    = bit_index;
    endtask

    task automatic random_traffic(input int n_ticks);
        int                  counted;
        logic                was_idle;
        i2cm_pkg::req_item_t op;
        counted = 0;
        while (counted < n_ticks)
        begin
            was_idle = (eng_phase == P_IDLE);
            if (!was_idle)
                op = bus_tick(busy_cmd(), 8'($urandom), 1'($urandom));
            else if ($urandom_range(0, 99) < 10)
                op = bus_tick(3'($urandom), 8'($urandom), 1'($urandom));
            else if ($urandom_range(0, 99) < 15)
                op = bus_tick(i2cm_pkg::CMD_NONE, 8'($urandom), 1'($urandom));
            else
            begin
                if (bus_script.size() == 0)
                    plan_transaction();
                op = bus_script.pop_front();
                op = bus_tick(op.cmd, op.tx_data, op.nack_after_read);
            end
            send_request(op);
            // Idle samples that start nothing do not count toward the total.
            if (!was_idle || eng_phase != P_IDLE)
                counted++;
        end
    endtask

    task automatic test_directed_commands();
        scl_low_pct    = 0;
        nack_pct       = 0;
        busy_noise_pct = 0;
        force_low_en   = 1'b0;
        issue(i2cm_pkg::CMD_START, 8'h00, 1'b0);
        nack_pct = 100;
        issue(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b1);
        nack_pct = 0;
        issue(i2cm_pkg::CMD_READ, 8'h00, 1'b0);
        issue(i2cm_pkg::CMD_START, 8'h5A, 1'b0);
        // Every command offered during this write must be ignored.
        busy_noise_pct = 100;
        issue(i2cm_pkg::CMD_WRITE, 8'hA5, 1'b0);
        busy_noise_pct = 0;
        issue(i2cm_pkg::CMD_STOP, 8'h00, 1'b0);
        // Commands without a preceding START still run on the bus.
        issue(i2cm_pkg::CMD_STOP, 8'hFF, 1'b1);
        issue(i2cm_pkg::CMD_READ, 8'hC3, 1'b1);
        issue(i2cm_pkg::CMD_NONE, 8'hFF, 1'b1);
        for (int k = 1; k <= 3; k++)
            issue(i2cm_pkg::CMD_READ + 3'(k), 8'($urandom), 1'($urandom));
        nack_pct = 20;
    endtask

    task automatic test_clock_stretch();
        write_stretch_limit(8'd0);
        issue(i2cm_pkg::CMD_START, 8'h00, 1'b0);
        hold_scl_low(P_ST_WAIT, -1);
        issue(i2cm_pkg::CMD_START, 8'h00, 1'b0);
        hold_scl_low(P_WR_WAIT, 3);
        issue(i2cm_pkg::CMD_WRITE, 8'hC3, 1'b0);
        hold_scl_low(P_WR_AWAIT, -1);
        issue(i2cm_pkg::CMD_WRITE, 8'h81, 1'b0);
        hold_scl_low(P_RD_WAIT, 5);
        issue(i2cm_pkg::CMD_READ, 8'h00, 1'b0);
        hold_scl_low(P_RD_AWAIT, -1);
        issue(i2cm_pkg::CMD_READ, 8'h00, 1'b1);
        hold_scl_low(P_SP_WAIT, -1);
        issue(i2cm_pkg::CMD_STOP, 8'h00, 1'b0);
        force_low_en = 1'b0;

        // The longest stretch the limit allows, ending in a timeout on one bit.
        write_stretch_limit(8'd24);
        issue(i2cm_pkg::CMD_START, 8'h00, 1'b0);
        hold_scl_low(P_WR_WAIT, 0);
        issue(i2cm_pkg::CMD_WRITE, 8'($urandom), 1'b0);
        force_low_en = 1'b0;
        issue(i2cm_pkg::CMD_STOP, 8'h00, 1'b0);
    endtask

    task automatic test_random_traffic();
        logic [7:0] limits[4];
        int         low_pcts[4];
        limits   = '{8'd1, 8'd255, 8'($urandom), 8'd2};
        low_pcts = '{10, 30, $urandom_range(0, 40), 20};
        busy_noise_pct = 10;
        for (int chunk = 0; chunk < 4; chunk++)
        begin
            write_stretch_limit(limits[chunk]);
            scl_low_pct = low_pcts[chunk];
            gaps_on     = (chunk != 2);
            random_traffic(25);
        end
        gaps_on = 1'b1;
    endtask

    // The receiver stops for a long stretch while requests keep coming, so the
    // queues fill and full must hold the sender off.
    task automatic test_backpressure();
        wait_for_drain();
        gaps_on     = 1'b0;
        scl_low_pct = 5;
        @(posedge clk);
        pop_hold = 80;
        @(negedge clk);
        random_traffic(40);
        wait_for_drain();
        gaps_on     = 1'b1;
        scl_low_pct = 0;
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (pop_hold > 0)
        begin
            pop <= 1'b0;
            pop_hold--;
        end
        else if (pop_stall > 0)
        begin
            pop <= 1'b0;
            pop_stall--;
        end
        else
        begin
            pop <= 1'b1;
            pop_stall = pick_gap();
        end
    end

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR at %0t ns, result %0d: %s", $time, results_checked, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
            note_error($sformatf("%s expected %h, got %h", name, want, got));
    endtask

    always @(posedge clk)
    begin : check_results
        i2cm_pkg::res_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (tick_results_due.size() == 0)
            begin
                note_error($sformatf("result %h with no request outstanding", result));
            end
            else
            begin
                want = tick_results_due.pop_front();
                check_field("scl_drive_low", 8'(want.scl_drive_low), 8'(result.scl_drive_low));
                check_field("sda_drive_low", 8'(want.sda_drive_low), 8'(result.sda_drive_low));
                check_field("busy_res", 8'(want.busy_res), 8'(result.busy_res));
                check_field("done_res", 8'(want.done_res), 8'(result.done_res));
                check_field("rx_data", want.rx_data, result.rx_data);
                check_field("status", 8'(want.status), 8'(result.status));
                check_field("bus_active", 8'(want.bus_active), 8'(result.bus_active));
            end
            results_checked++;
        end
    end

    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        push        = 1'b0;
        request     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 8'd0;
        reset_engine_model();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_commands();
        test_clock_stretch();
        test_random_traffic();
        test_backpressure();

        wait_for_drain();
        repeat (10) @(negedge clk);
        if (tick_results_due.size() != 0)
            note_error($sformatf("%0d results never arrived", tick_results_due.size()));

        $display("Sent %0d bus samples; commands taken: %0d start, %0d stop, %0d write, %0d read.",
                 ticks_sent,
                 cmds_taken[i2cm_pkg::CMD_START], cmds_taken[i2cm_pkg::CMD_STOP],
                 cmds_taken[i2cm_pkg::CMD_WRITE], cmds_taken[i2cm_pkg::CMD_READ]);
        $display("Commands ended %0d ok, %0d slave NACK, %0d stretch timeout; %0d results checked.",
                 done_by_status[i2cm_pkg::ST_OK], done_by_status[i2cm_pkg::ST_NACK],
                 done_by_status[i2cm_pkg::ST_TIMEOUT], results_checked);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/i2cm_pkg.sv
sv/i2cm_queue.sv
sv/i2cm_front.sv
sv/i2cm_seq.sv
sv/i2c_master_byte_engine.sv
sv/i2cm_checker.sv
tb/testbench.sv
